/* design/i2cmts_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared types, bus status codes and control mask bits for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmts_pkg;

    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] POS_MAX = 9'd511;

    // Item operations.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EVENT = 2'd1,
        OP_START = 2'd2
    } t_op;

    // Transfer status as reported in every result.
    typedef enum logic [2:0] {
        XS_IDLE      = 3'd0,
        XS_STARTED   = 3'd1,
        XS_NO_DATA   = 3'd2,
        XS_OK        = 3'd3,
        XS_NACK_DATA = 3'd4,
        XS_NACK_ADDR = 3'd5,
        XS_ARB_LOST  = 3'd6
    } t_xfer;

    // Controller bus status codes.
    localparam logic [7:0] BS_START        = 8'h08;
    localparam logic [7:0] BS_RESTART      = 8'h10;
    localparam logic [7:0] BS_ADDR_ACK     = 8'h18;
    localparam logic [7:0] BS_ADDR_NACK    = 8'h20;
    localparam logic [7:0] BS_DATA_ACK     = 8'h28;
    localparam logic [7:0] BS_DATA_NACK    = 8'h30;
    localparam logic [7:0] BS_ARB_LOST     = 8'h38;
    localparam logic [7:0] BS_RD_ADDR_ACK  = 8'h40;
    localparam logic [7:0] BS_RD_ADDR_NACK = 8'h48;
    localparam logic [7:0] BS_RX_ACK       = 8'h50;
    localparam logic [7:0] BS_RX_NACK      = 8'h58;

    // Control bits to set.
    localparam logic [2:0] SET_START = 3'b001;
    localparam logic [2:0] SET_STOP  = 3'b010;
    localparam logic [2:0] SET_ACK   = 3'b100;

    // Control bits to clear.
    localparam logic [3:0] CLR_ACK   = 4'b0001;
    localparam logic [3:0] CLR_SI    = 4'b0010;
    localparam logic [3:0] CLR_START = 4'b0100;
    localparam logic [3:0] CLR_STOP  = 4'b1000;

    // Configuration register indexes.
    localparam logic CFG_WRITE_LENGTH = 1'b0;
    localparam logic CFG_READ_LENGTH  = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] load_index;
        logic [7:0] load_byte;
        logic [7:0] status_code;
        logic [7:0] received_byte;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] set_mask;
        logic [3:0] clear_mask;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [3:0] rx_index;
        logic [2:0] transfer_status;
    } t_result;

    typedef struct packed {
        logic [POS_W-1:0] wpos;
        logic [POS_W-1:0] rpos;
        t_xfer            status;
    } t_seq_state;

    // Tells the store address counter how to follow the write position.
    typedef struct packed {
        logic restart;
        logic advance;
    } t_addr_ctl;

    function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p);
        return (p < POS_MAX) ? p + 9'd1 : POS_MAX;
    endfunction

endpackage

`default_nettype wire

/* design/i2cmts_if.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer channels
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [3:0] load_index;
    logic [7:0] load_byte;
    logic [7:0] status_code;
    logic [7:0] received_byte;

    modport source (output valid, operation, load_index, load_byte, status_code,
                    received_byte, input ready);
    modport sink (input valid, operation, load_index, load_byte, status_code,
                  received_byte, output ready);
endinterface

interface i2cmts_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] set_mask;
    logic [3:0] clear_mask;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [3:0] rx_index;
    logic [2:0] transfer_status;

    modport source (output valid, tx_valid, tx_byte, set_mask, clear_mask, rx_valid,
                    rx_byte, rx_index, transfer_status, input ready);
    modport sink (input valid, tx_valid, tx_byte, set_mask, clear_mask, rx_valid,
                  rx_byte, rx_index, transfer_status, output ready);
endinterface

interface i2cmts_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [4:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/i2cmts_ctrl.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer decision logic
// Maps one item and the current sequencer state to a result and next state.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmts_ctrl
    import i2cmts_pkg::*;
(
    input  var t_item      i_item,
    input  var t_seq_state i_state,
    input  wire [4:0]      i_write_length,
    input  wire [4:0]      i_read_length,
    input  wire [7:0]      i_store_byte,
    input  wire [7:0]      i_first_byte,
    output t_seq_state     o_state,
    output t_result        o_result,
    output t_addr_ctl      o_addr_ctl
);

    logic       fetch;
    logic       restart;
    logic [2:0] set_mask;
    logic [3:0] clear_mask;
    logic       rx_valid;
    t_seq_state nxt;

    always_comb begin
        nxt        = i_state;
        fetch      = 1'b0;
        restart    = 1'b0;
        set_mask   = '0;
        clear_mask = '0;
        rx_valid   = 1'b0;

        case (i_item.operation)
            OP_LOAD: begin
            end
            OP_START: begin
                set_mask   = SET_START;
                nxt.status = XS_STARTED;
            end
            OP_EVENT: begin
                clear_mask = CLR_SI;
                case (i_item.status_code)
                    BS_START: begin
                        nxt.rpos   = '0;
                        fetch      = 1'b1;
                        restart    = 1'b1;
                        clear_mask = clear_mask | CLR_START;
                    end
                    BS_RESTART: begin
                        nxt.rpos   = '0;
                        fetch      = 1'b1;
                        clear_mask = clear_mask | CLR_START;
                    end
                    BS_ADDR_ACK: begin
                        if (i_write_length == 5'd1) begin
                            set_mask   = SET_STOP;
                            nxt.status = XS_NO_DATA;
                        end else begin
                            clear_mask = clear_mask | CLR_STOP | CLR_START;
                            fetch      = 1'b1;
                        end
                    end
                    BS_DATA_ACK: begin
                        if (i_state.wpos < {4'b0, i_write_length}) begin
                            fetch = 1'b1;
                        end else if (i_read_length != 5'd0) begin
                            set_mask = SET_START;
                        end else begin
                            set_mask   = SET_STOP;
                            nxt.status = XS_OK;
                        end
                    end
                    BS_DATA_NACK: begin
                        set_mask   = SET_STOP;
                        nxt.status = XS_NACK_DATA;
                    end
                    BS_RD_ADDR_ACK, BS_RX_ACK: begin
                        if (i_item.status_code == BS_RX_ACK) begin
                            rx_valid = 1'b1;
                            nxt.rpos = bump(i_state.rpos);
                        end
                        // Ack the next byte only if more than one is still to come.
                        if (({1'b0, nxt.rpos} + 10'd1) < {5'b0, i_read_length}) begin
                            set_mask = SET_ACK;
                        end else begin
                            clear_mask = clear_mask | CLR_ACK;
                        end
                    end
                    BS_RX_NACK: begin
                        rx_valid   = 1'b1;
                        nxt.rpos   = bump(i_state.rpos);
                        nxt.status = XS_OK;
                        set_mask   = SET_STOP;
                    end
                    BS_ADDR_NACK, BS_RD_ADDR_NACK: begin
                        set_mask   = SET_STOP;
                        nxt.status = XS_NACK_ADDR;
                    end
                    BS_ARB_LOST: begin
                        nxt.status = XS_ARB_LOST;
                    end
                    default: begin
                        nxt.status = XS_ARB_LOST;
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (fetch) begin
            nxt.wpos = bump(restart ? '0 : i_state.wpos);
        end
    end

    assign o_state             = nxt;
    assign o_addr_ctl.restart  = restart;
    assign o_addr_ctl.advance  = fetch && !restart && (i_state.wpos != POS_MAX);

    assign o_result.tx_valid        = fetch;
    assign o_result.tx_byte         = fetch ? (restart ? i_first_byte : i_store_byte) : 8'd0;
    assign o_result.set_mask        = set_mask;
    assign o_result.clear_mask      = clear_mask;
    assign o_result.rx_valid        = rx_valid;
    assign o_result.rx_byte         = rx_valid ? i_item.received_byte : 8'd0;
    assign o_result.rx_index        = rx_valid ? i_state.rpos[3:0] : 4'd0;
    assign o_result.transfer_status = nxt.status;

endmodule

`default_nettype wire

/* design/i2c_master_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Write-then-read master transfer sequencing driven by controller status codes.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : register writes (index 0 write_length, index 1 read_length).
//            Always ready; write only while no item is in flight.
//   i_in   : items (load a write buffer byte, bus status event, request start).
//   o_out  : exactly one result beat per item, in order.
// An accepted item passes through the input register and then the result
// register, where its result beat is held until it is taken. One item is
// accepted every cycle as long as results are taken; the next transmit
// byte is read from the buffer memory into a register ahead of use, at the
// updated write position.
// When o_out stalls, the result register holds its beat and the input
// register still takes one more item; i_in.ready then drops until the
// result is taken.
// Reset clears the positions, the transfer status (idle), both lengths and
// the valid flags. The write buffer is not cleared and must be loaded before
// it is used.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer
    import i2cmts_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    i2cmts_cfg_if.sink    i_cfg,
    i2cmts_in_if.sink     i_in,
    i2cmts_out_if.source  o_out
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

    // Load index modulo the buffer depth, by repeated subtraction.
    function automatic logic [AW-1:0] wrap_index(input logic [3:0] idx);
        logic [8:0] v;
        v = {5'b0, idx};
        for (int k = 0; k < 8; k++) begin
            if (v >= 9'(BUFFER_DEPTH)) begin
                v = v - 9'(BUFFER_DEPTH);
            end
        end
        return v[AW-1:0];
    endfunction

    logic [7:0] r_store [BUFFER_DEPTH];
    logic [7:0] r_store_byte;
    logic [7:0] r_first_byte;
    logic [AW-1:0] r_waddr;
    logic [AW-1:0] n_waddr;

    logic [4:0] r_write_length;
    logic [4:0] r_read_length;

    logic       r_s1_valid;
    t_item      r_s1_item;
    t_seq_state r_state;
    t_seq_state n_state;

    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    t_addr_ctl  addr_ctl;

    logic          s1_fire;
    logic          in_fire;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign s1_fire = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_fire = i_in.valid && i_in.ready;
    assign wr_en   = s1_fire && (r_s1_item.operation == OP_LOAD);
    assign wr_addr = wrap_index(r_s1_item.load_index);

    assign i_in.ready  = !r_s1_valid || s1_fire;
    assign i_cfg.ready = 1'b1;

    i2cmts_ctrl u_ctrl (
        .i_item         (r_s1_item),
        .i_state        (r_state),
        .i_write_length (r_write_length),
        .i_read_length  (r_read_length),
        .i_store_byte   (r_store_byte),
        .i_first_byte   (r_first_byte),
        .o_state        (n_state),
        .o_result       (n_out),
        .o_addr_ctl     (addr_ctl)
    );

    always_comb begin
        n_waddr = r_waddr;
        if (addr_ctl.restart) begin
            n_waddr = AW'(1);
        end else if (addr_ctl.advance) begin
            n_waddr = (r_waddr == LAST_ADDR) ? '0 : r_waddr + AW'(1);
        end
    end

    // Buffer memory; the read port follows the write position one item ahead.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= r_s1_item.load_byte;
        end
        if (s1_fire) begin
            if (wr_en && (wr_addr == n_waddr)) begin
                r_store_byte <= r_s1_item.load_byte;
            end else begin
                r_store_byte <= r_store[n_waddr];
            end
        end
        // Copy of entry zero for the byte sent right after a start.
        if (wr_en && (wr_addr == '0)) begin
            r_first_byte <= r_s1_item.load_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_length <= '0;
            r_read_length  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WRITE_LENGTH: r_write_length <= i_cfg.data;
                CFG_READ_LENGTH:  r_read_length  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{wpos: '0, rpos: '0, status: XS_IDLE};
            r_waddr     <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_waddr     <= n_waddr;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item.operation     <= i_in.operation;
            r_s1_item.load_index    <= i_in.load_index;
            r_s1_item.load_byte     <= i_in.load_byte;
            r_s1_item.status_code   <= i_in.status_code;
            r_s1_item.received_byte <= i_in.received_byte;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.tx_valid        = r_out.tx_valid;
    assign o_out.tx_byte         = r_out.tx_byte;
    assign o_out.set_mask        = r_out.set_mask;
    assign o_out.clear_mask      = r_out.clear_mask;
    assign o_out.rx_valid        = r_out.rx_valid;
    assign o_out.rx_byte         = r_out.rx_byte;
    assign o_out.rx_index        = r_out.rx_index;
    assign o_out.transfer_status = r_out.transfer_status;

endmodule

`default_nettype wire

/* bench/tb_i2c_master_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Drives load, start and bus status items through the item channel, tracks the
// expected control actions with a scoreboard that mirrors the sequencing rules,
// and compares every result beat field by field. Lengths are reprogrammed
// between drained phases, and both position counters are driven into
// saturation once.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer;
    import i2cmts_pkg::*;

    localparam int DEPTH        = 16;
    localparam int STIM_END     = 1350;
    localparam int SATURATE_AT  = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 60;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    class transfer_scoreboard;
        logic [7:0]       store [DEPTH];
        bit               loaded [DEPTH];
        logic [POS_W-1:0] wpos;
        logic [POS_W-1:0] rpos;
        t_xfer            status;
        logic [4:0]       wr_len;
        logic [4:0]       rd_len;
        t_result          awaited_actions [$];
        int               errors;

        function new();
            foreach (loaded[i]) loaded[i] = 1'b0;
            wpos   = '0;
            rpos   = '0;
            status = XS_IDLE;
            wr_len = '0;
            rd_len = '0;
            errors = 0;
        endfunction

        function logic [POS_W-1:0] advanced(input logic [POS_W-1:0] p);
            return (p == POS_MAX) ? p : p + 9'd1;
        endfunction

        function logic [7:0] pull_tx();
            logic [7:0] b;
            b = store[wpos % DEPTH];
            wpos = advanced(wpos);
            return b;
        endfunction

        // Store position that this item would transmit from while it was never
        // loaded, or -1 when the item reads nothing or reads a loaded entry.
        function int unloaded_read(input t_item it);
            int  addr;
            bit  reads;
            addr  = wpos % DEPTH;
            reads = 1'b0;
            if (it.operation == OP_EVENT) begin
                case (it.status_code)
                    BS_START: begin
                        addr  = 0;
                        reads = 1'b1;
                    end
                    BS_RESTART:  reads = 1'b1;
                    BS_ADDR_ACK: reads = (wr_len != 5'd1);
                    BS_DATA_ACK: reads = (wpos < 9'(wr_len));
                    default: ;
                endcase
            end
            return (reads && !loaded[addr]) ? addr : -1;
        endfunction

        function void note_item(input t_item it);
            t_result r;
            r = '0;
            case (it.operation)
                OP_LOAD: begin
                    store[it.load_index]  = it.load_byte;
                    loaded[it.load_index] = 1'b1;
                end
                OP_START: begin
                    r.set_mask = SET_START;
                    status = XS_STARTED;
                end
                OP_EVENT: begin
                    r.clear_mask = CLR_SI;
                    case (it.status_code)
                        BS_START: begin
                            wpos = '0;
                            rpos = '0;
                            r.tx_valid = 1'b1;
                            r.tx_byte = pull_tx();
                            r.clear_mask |= CLR_START;
                        end
                        BS_RESTART: begin
                            rpos = '0;
                            r.tx_valid = 1'b1;
                            r.tx_byte = pull_tx();
                            r.clear_mask |= CLR_START;
                        end
                        BS_ADDR_ACK: begin
                            if (wr_len == 5'd1) begin
                                r.set_mask = SET_STOP;
                                status = XS_NO_DATA;
                            end else begin
                                r.clear_mask |= CLR_STOP | CLR_START;
                                r.tx_valid = 1'b1;
                                r.tx_byte = pull_tx();
                            end
                        end
                        BS_DATA_ACK: begin
                            if (wpos < 9'(wr_len)) begin
                                r.tx_valid = 1'b1;
                                r.tx_byte = pull_tx();
                            end else if (rd_len != 5'd0) begin
                                r.set_mask = SET_START;
                            end else begin
                                r.set_mask = SET_STOP;
                                status = XS_OK;
                            end
                        end
                        BS_DATA_NACK: begin
                            r.set_mask = SET_STOP;
                            status = XS_NACK_DATA;
                        end
                        BS_RD_ADDR_ACK, BS_RX_ACK: begin
                            if (it.status_code == BS_RX_ACK) begin
                                r.rx_valid = 1'b1;
                                r.rx_byte  = it.received_byte;
                                r.rx_index = rpos[3:0];
                                rpos = advanced(rpos);
                            end
                            // Acknowledge only while more than one byte is still to come.
                            if (10'(rpos) + 10'd1 < 10'(rd_len)) r.set_mask = SET_ACK;
                            else r.clear_mask |= CLR_ACK;
                        end
                        BS_RX_NACK: begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = it.received_byte;
                            r.rx_index = rpos[3:0];
                            rpos = advanced(rpos);
                            r.set_mask = SET_STOP;
                            status = XS_OK;
                        end
                        BS_ADDR_NACK, BS_RD_ADDR_NACK: begin
                            r.set_mask = SET_STOP;
                            status = XS_NACK_ADDR;
                        end
                        default: status = XS_ARB_LOST;
                    endcase
                end
                default: ;
            endcase
            r.transfer_status = status;
            awaited_actions.push_back(r);
        endfunction

        function void match(input string field, input logic [7:0] want, input logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (awaited_actions.size() == 0) begin
                $error("result beat arrived with no expected result waiting");
                errors++;
                return;
            end
            want = awaited_actions.pop_front();
            match("tx_valid", want.tx_valid, got.tx_valid);
            match("tx_byte", want.tx_byte, got.tx_byte);
            match("set_mask", want.set_mask, got.set_mask);
            match("clear_mask", want.clear_mask, got.clear_mask);
            match("rx_valid", want.rx_valid, got.rx_valid);
            match("rx_byte", want.rx_byte, got.rx_byte);
            match("rx_index", want.rx_index, got.rx_index);
            match("transfer_status", want.transfer_status, got.transfer_status);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cmts_in_if  in_bus ();
    i2cmts_out_if out_bus ();
    i2cmts_cfg_if cfg_bus ();

    transfer_scoreboard sb = new();
    int sent = 0;
    bit calm = 1'b0;

    i2c_master_transfer_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_item item_of(input logic [1:0] op, input logic [3:0] idx,
                                      input logic [7:0] value, input logic [7:0] code,
                                      input logic [7:0] rx);
        t_item it;
        it.operation     = op;
        it.load_index    = idx;
        it.load_byte     = value;
        it.status_code   = code;
        it.received_byte = rx;
        return it;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.operation     = 2'($urandom_range(0, 3));
        it.load_index    = 4'($urandom);
        it.load_byte     = 8'($urandom);
        it.received_byte = 8'($urandom);
        case ($urandom_range(0, 11))
            0:  it.status_code = BS_START;
            1:  it.status_code = BS_RESTART;
            2:  it.status_code = BS_ADDR_ACK;
            3:  it.status_code = BS_ADDR_NACK;
            4:  it.status_code = BS_DATA_ACK;
            5:  it.status_code = BS_DATA_NACK;
            6:  it.status_code = BS_ARB_LOST;
            7:  it.status_code = BS_RD_ADDR_ACK;
            8:  it.status_code = BS_RD_ADDR_NACK;
            9:  it.status_code = BS_RX_ACK;
            10: it.status_code = BS_RX_NACK;
            default: it.status_code = 8'($urandom);
        endcase
        return it;
    endfunction

    function automatic logic [4:0] pick_len();
        case ($urandom_range(0, 5))
            0: return 5'd0;
            1: return 5'd16;
            2: return 5'd1;
            default: return 5'($urandom_range(0, 16));
        endcase
    endfunction

    task automatic send_item(input t_item it);
        int idx;
        // Never transmit from a store entry that was never loaded: load it instead.
        idx = sb.unloaded_read(it);
        if (idx >= 0) begin
            it.operation  = OP_LOAD;
            it.load_index = idx[3:0];
        end
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.operation     <= it.operation;
        in_bus.load_index    <= it.load_index;
        in_bus.load_byte     <= it.load_byte;
        in_bus.status_code   <= it.status_code;
        in_bus.received_byte <= it.received_byte;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        sb.note_item(it);
        sent++;
    endtask

    task automatic event_beat(input logic [7:0] code);
        t_item it;
        if ($urandom_range(0, 39) == 0) send_item(rand_item());
        it = rand_item();
        it.operation   = OP_EVENT;
        it.status_code = code;
        send_item(it);
    endtask

    task automatic load_beat(input logic [3:0] idx);
        t_item it;
        it = rand_item();
        it.operation  = OP_LOAD;
        it.load_index = idx;
        send_item(it);
    endtask

    task automatic settle();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_actions.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_lengths(input logic [4:0] wl, input logic [4:0] rl);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_WRITE_LENGTH;
        cfg_bus.data  <= wl;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        sb.wr_len = wl;
        cfg_bus.index <= CFG_READ_LENGTH;
        cfg_bus.data  <= rl;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        sb.rd_len = rl;
        cfg_bus.valid <= 1'b0;
    endtask

    // One write-then-read transfer as the controller would report it, with
    // occasional early aborts.
    task automatic run_transfer();
        int   k;
        t_item it;
        for (k = 0; k <= int'(sb.wr_len); k++)
            if ($urandom_range(0, 3) != 0) load_beat(4'(k % DEPTH));
        it = rand_item();
        it.operation = OP_START;
        send_item(it);
        event_beat(BS_START);
        case ($urandom_range(0, 19))
            0: begin
                event_beat(BS_ADDR_NACK);
                return;
            end
            1: begin
                event_beat(BS_ARB_LOST);
                return;
            end
            default: ;
        endcase
        event_beat(BS_ADDR_ACK);
        if (sb.wr_len == 5'd1) return;
        while (sb.wpos < 9'(sb.wr_len)) begin
            if ($urandom_range(0, 24) == 0) begin
                event_beat(BS_DATA_NACK);
                return;
            end
            event_beat(BS_DATA_ACK);
        end
        // Last data beat: either the stop or the repeated start request.
        event_beat(BS_DATA_ACK);
        if (sb.rd_len == 5'd0) return;
        event_beat(BS_RESTART);
        if ($urandom_range(0, 9) == 0) begin
            event_beat(BS_RD_ADDR_NACK);
            return;
        end
        event_beat(BS_RD_ADDR_ACK);
        while (10'(sb.rpos) + 10'd1 < 10'(sb.rd_len)) event_beat(BS_RX_ACK);
        event_beat(BS_RX_NACK);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready)
            sb.check_result({out_bus.tx_valid, out_bus.tx_byte, out_bus.set_mask,
                             out_bus.clear_mask, out_bus.rx_valid, out_bus.rx_byte,
                             out_bus.rx_index, out_bus.transfer_status});
    end

    initial begin : result_sink
        bit held;
        held = 1'b0;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && sent >= HOLD_AT) begin
                // Long hold-off: both internal registers fill and the input stalls.
                held = 1'b1;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                out_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_item it;
        int    k;
        bit    saturated;
        saturated = 1'b0;
        in_bus.valid         <= 1'b0;
        in_bus.operation     <= OP_LOAD;
        in_bus.load_index    <= '0;
        in_bus.load_byte     <= '0;
        in_bus.status_code   <= '0;
        in_bus.received_byte <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= CFG_WRITE_LENGTH;
        cfg_bus.data         <= '0;
        i_rst_n              <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one complete write-then-read transfer, then every other code.
        program_lengths(5'd3, 5'd2);
        send_item(item_of(OP_LOAD, 4'd0, 8'h00, 8'h00, 8'h00));
        send_item(item_of(OP_LOAD, 4'd15, 8'hFF, 8'hFF, 8'hFF));
        send_item(item_of(OP_LOAD, 4'd1, 8'h5A, 8'h00, 8'h00));
        send_item(item_of(OP_LOAD, 4'd2, 8'hA5, 8'h00, 8'h00));
        send_item(item_of(OP_LOAD, 4'd3, 8'hC3, 8'h00, 8'h00));
        send_item(item_of(OP_UNUSED, 4'hF, 8'hFF, 8'hFF, 8'hFF));
        send_item(item_of(OP_START, 4'd0, 8'h00, 8'h00, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_START, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_ADDR_ACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_DATA_ACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_DATA_ACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_RESTART, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_RD_ADDR_ACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_RX_ACK, 8'hFF));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_RX_NACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_DATA_NACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_ADDR_NACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_RD_ADDR_NACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_ARB_LOST, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, 8'h00, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, 8'hFF, 8'h00));
        // Address only, then a write-only finish.
        settle();
        program_lengths(5'd1, 5'd0);
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_START, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_ADDR_ACK, 8'h00));
        send_item(item_of(OP_EVENT, 4'd0, 8'h00, BS_DATA_ACK, 8'h00));

        while (sent < STIM_END) begin
            calm = (sent >= STIM_END - 150);
            if (!saturated && sent >= SATURATE_AT) begin
                // Drive both position counters into saturation and past it.
                saturated = 1'b1;
                settle();
                program_lengths(5'd16, 5'd16);
                for (k = 0; k < DEPTH; k++) load_beat(4'(k));
                event_beat(BS_START);
                for (k = 0; k < 1060; k++) begin
                    it = rand_item();
                    it.operation = OP_EVENT;
                    if (sb.wpos != POS_MAX && (sb.rpos == POS_MAX || $urandom_range(0, 1) == 0))
                        it.status_code = BS_ADDR_ACK;
                    else
                        it.status_code = BS_RX_ACK;
                    send_item(it);
                end
            end else if ($urandom_range(0, 3) == 0) begin
                settle();
                program_lengths(pick_len(), pick_len());
            end else if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) send_item(rand_item());
            end else begin
                run_transfer();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited_actions.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 12);
        $display("Some tests failed");
        $finish;
    end

endmodule
